// ----- rtl/core/command_frame_deframer_macros.svh -----
// Assertion macros for the deframer, used by cfd_framer.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef COMMAND_FRAME_DEFRAMER_MACROS_SVH
`define COMMAND_FRAME_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CFD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/cfd_pkg.sv -----
package cfd_pkg;

	// Header, tail and digit characters.
	localparam logic [7:0] CHAR_S_LOWER = 8'h73;
	localparam logic [7:0] CHAR_C_LOWER = 8'h63;
	localparam logic [7:0] CHAR_D_LOWER = 8'h64;
	localparam logic [7:0] CHAR_C       = 8'h43;
	localparam logic [7:0] CHAR_M       = 8'h4D;
	localparam logic [7:0] CHAR_D       = 8'h44;
	localparam logic [7:0] CHAR_E       = 8'h45;
	localparam logic [7:0] CHAR_O       = 8'h4F;
	localparam logic [7:0] CHAR_L       = 8'h4C;
	localparam logic [7:0] CHAR_CR      = 8'h0D;
	localparam logic [7:0] ASCII_ZERO   = 8'd48;

	// Frame geometry.
	localparam int DRIVE_PAYLOAD_BYTES = 4;
	localparam int DIGIT_PAYLOAD_BYTES = 1;
	localparam int TAIL_BYTES          = 4;
	localparam int POS_W               = 3;
	localparam logic [POS_W-1:0] DRIVE_LAST_POS =
		POS_W'(DRIVE_PAYLOAD_BYTES + TAIL_BYTES - 1);
	localparam logic [POS_W-1:0] DIGIT_LAST_POS =
		POS_W'(DIGIT_PAYLOAD_BYTES + TAIL_BYTES - 1);
	localparam logic [POS_W-1:0] WINDOW_LAST_POS = POS_W'(DRIVE_PAYLOAD_BYTES - 1);

	// Configuration register indexes.
	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] REG_STATE_COUNT  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_CONFIG_COUNT = 2'd1;
	localparam logic [7:0] STATE_COUNT_RESET  = 8'd8;
	localparam logic [7:0] CONFIG_COUNT_RESET = 8'd8;

	typedef enum logic [1:0] {
		KIND_STATE  = 2'd0,
		KIND_CONFIG = 2'd1,
		KIND_DRIVE  = 2'd2
	} kind_t;

	typedef enum logic {
		PHASE_HUNT    = 1'b0,
		PHASE_COLLECT = 1'b1
	} phase_t;

	typedef struct packed {
		kind_t       command_kind;
		logic [15:0] value_first;
		logic [15:0] value_second;
		logic        index_ok;
		logic        ended_early;
	} result_t;

endpackage

// ----- rtl/core/cfd_framer.sv -----
`include "command_frame_deframer_macros.svh"

module cfd_framer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	input  logic [7:0]        rx_byte,
	input  logic [7:0]        state_count,
	input  logic [7:0]        config_command_count,
	output logic              res_valid,
	output cfd_pkg::result_t  res
);
	import cfd_pkg::*;

	phase_t             phase_q, phase_d;
	logic [1:0]         matched_q, matched_d;
	kind_t              kind_q, kind_d;
	logic [POS_W-1:0]   pos_q, pos_d;
	logic [31:0]        window_q, window_d;
	logic [23:0]        recent_q, recent_d;

	logic [POS_W-1:0]   last_pos;
	logic               full_end;
	logic               tail_hit;
	logic               done;
	logic               header_done;
	logic [7:0]         want;
	logic [7:0]         digit;
	logic [7:0]         digit_off;
	logic [7:0]         limit;

	// Frame end detection on the current byte.
	assign last_pos  = (kind_q == KIND_DRIVE) ? DRIVE_LAST_POS : DIGIT_LAST_POS;
	assign full_end  = (pos_q == last_pos);
	assign tail_hit  = (pos_q > WINDOW_LAST_POS) && (rx_byte == CHAR_CR) &&
		(recent_q == {CHAR_E, CHAR_O, CHAR_L});
	assign done      = (phase_q == PHASE_COLLECT) && (tail_hit || full_end);

	// Second to fourth header characters.
	always_comb begin
		unique case (matched_q)
			2'd1:    want = CHAR_C;
			2'd2:    want = CHAR_M;
			default: want = CHAR_D;
		endcase
	end
	assign header_done = (matched_q == 2'd3) && (rx_byte == want);

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		if (byte_valid) begin
			unique case (phase_q)
				PHASE_HUNT:    if (header_done) phase_d = PHASE_COLLECT;
				PHASE_COLLECT: if (done) phase_d = PHASE_HUNT;
				default:       phase_d = PHASE_HUNT;
			endcase
		end
	end

	// Header match, collection counters and windows.
	always_comb begin
		matched_d = matched_q;
		kind_d    = kind_q;
		pos_d     = pos_q;
		window_d  = window_q;
		recent_d  = recent_q;
		if (byte_valid) begin
			if (phase_q == PHASE_HUNT) begin
				if (matched_q == 2'd0) begin
					if (rx_byte == CHAR_S_LOWER) begin
						kind_d    = KIND_STATE;
						matched_d = 2'd1;
					end else if (rx_byte == CHAR_C_LOWER) begin
						kind_d    = KIND_CONFIG;
						matched_d = 2'd1;
					end else if (rx_byte == CHAR_D_LOWER) begin
						kind_d    = KIND_DRIVE;
						matched_d = 2'd1;
					end
				end else if (rx_byte == want) begin
					matched_d = matched_q + 2'd1;
					if (header_done) begin
						matched_d = 2'd0;
						pos_d     = '0;
						window_d  = '0;
					end
				end else begin
					// A mismatching byte is dropped, not retried as a start.
					matched_d = 2'd0;
				end
			end else begin
				if (pos_q <= WINDOW_LAST_POS) window_d = {window_q[23:0], rx_byte};
				recent_d = {recent_q[15:0], rx_byte};
				pos_d    = done ? '0 : pos_q + POS_W'(1);
				if (done) matched_d = 2'd0;
			end
		end
	end

	// Result fields, taken from the window before this byte.
	assign digit     = window_q[31:24];
	assign digit_off = digit - ASCII_ZERO;
	assign limit     = (kind_q == KIND_STATE) ? state_count : config_command_count;

	always_comb begin
		res.command_kind = kind_q;
		res.ended_early  = tail_hit && !full_end;
		if (kind_q == KIND_DRIVE) begin
			res.value_first  = window_q[31:16];
			res.value_second = window_q[15:0];
			res.index_ok     = 1'b1;
		end else begin
			res.value_first  = {8'h00, digit} - {8'h00, ASCII_ZERO};
			res.value_second = '0;
			res.index_ok     = (digit >= ASCII_ZERO) && (digit_off < limit);
		end
	end
	assign res_valid = byte_valid && done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PHASE_HUNT;
			matched_q <= 2'd0;
			kind_q    <= KIND_STATE;
			pos_q     <= '0;
			window_q  <= '0;
			recent_q  <= '0;
		end else begin
			phase_q   <= phase_d;
			matched_q <= matched_d;
			kind_q    <= kind_d;
			pos_q     <= pos_d;
			window_q  <= window_d;
			recent_q  <= recent_d;
		end
	end

	`CFD_ASSERT_NOW(a_hunt_pos_zero, phase_q == PHASE_HUNT, pos_q == '0, "position moved while hunting")
	`CFD_ASSERT_NOW(a_collect_no_match, phase_q == PHASE_COLLECT, matched_q == 2'd0, "header count kept during collection")
	`CFD_ASSERT_NEXT(a_result_ends_frame, res_valid, phase_q == PHASE_HUNT, "frame did not close after its result")
	`CFD_ASSERT_NOW(a_digit_frame_shape, res_valid && kind_q != KIND_DRIVE, res.value_second == '0 && !res.ended_early, "digit frame with drive fields")

endmodule

// ----- rtl/core/cfd_out_reg.sv -----
module cfd_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  cfd_pkg::result_t  res,
	input  logic              take,
	output logic              valid,
	output cfd_pkg::result_t  data
);
	import cfd_pkg::*;

	logic    valid_q;
	result_t data_q;

	// Valid flag: set on a new result, cleared once the word is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (take) begin
			valid_q <= 1'b0;
		end
	end

	// Payload holds until the next result is loaded.
	always_ff @(posedge clk) begin
		if (load) data_q <= res;
	end

	assign valid = valid_q;
	assign data  = data_q;

endmodule

// ----- rtl/core/command_frame_deframer.sv -----
// Command frame deframer: takes one received byte per word on the slave side and hunts for a
// header of 's', 'c' or 'd' followed by "CMD", then collects a one-digit payload (state or
// config) or four big-endian bytes (drive speed and angle) and the tail "EOL\r"; a drive frame
// also closes early when that tail appears before its full length. Every closed frame yields one
// result word on the master side, registered, in the cycle after the byte that closed the frame.
// A byte is taken every cycle; the only stall is a result still held in the output register while
// the master side does not take it. The user must write the counts through the configuration port
// only while the stream is idle; the block does not enforce it. Both reset to eight.
module command_frame_deframer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [7:0]                          s_tdata,   // [7:0] rx_byte
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [15:0] value_first, [31:16] value_second, [32] index_ok, [33] ended_early, [39:34] zero
	output logic [39:0]                         m_tdata,
	output logic [1:0]                          m_tuser,   // [1:0] command_kind
	input  logic                                cfg_we,
	input  logic [cfd_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [7:0]                          cfg_wdata
);
	import cfd_pkg::*;

	logic [7:0] state_count_q;
	logic [7:0] config_count_q;
	logic       accept;
	logic       res_valid;
	result_t    res;
	result_t    out_data;

	// Configuration registers; writes to other indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_count_q  <= STATE_COUNT_RESET;
			config_count_q <= CONFIG_COUNT_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_STATE_COUNT) state_count_q <= cfg_wdata;
			if (cfg_index == REG_CONFIG_COUNT) config_count_q <= cfg_wdata;
		end
	end

	// A byte is taken whenever the output register is free or is emptied this cycle.
	assign s_tready = !m_tvalid || m_tready;
	assign accept   = s_tvalid && s_tready;

	cfd_framer u_framer (
		.clk                  (clk),
		.arst_n               (arst_n),
		.byte_valid           (accept),
		.rx_byte              (s_tdata),
		.state_count          (state_count_q),
		.config_command_count (config_count_q),
		.res_valid            (res_valid),
		.res                  (res)
	);

	cfd_out_reg u_out_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (res_valid),
		.res    (res),
		.take   (m_tready),
		.valid  (m_tvalid),
		.data   (out_data)
	);

	// Pack the result word.
	assign m_tuser = out_data.command_kind;
	assign m_tdata = {6'b000000, out_data.ended_early, out_data.index_ok,
		out_data.value_second, out_data.value_first};

endmodule

// ----- sim/tb_command_frame_deframer.sv -----
`timescale 1ns / 100ps

module tb_command_frame_deframer;
	import cfd_pkg::*;

	// Indexes past the two counts; the block must ignore writes to them.
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;
	localparam int STALL_LIMIT  = 1000;
	localparam int PHASE_BYTES  = 320;
	localparam int PHASE_COUNT  = 5;

	// Predicts the result word of each frame from the accepted bytes and holds the
	// predictions until the master side delivers them.
	class frame_tracker;
		logic [7:0]       state_limit  = STATE_COUNT_RESET;
		logic [7:0]       config_limit = CONFIG_COUNT_RESET;
		phase_t           phase        = PHASE_HUNT;
		logic [2:0]       matched      = '0;
		kind_t            kind         = KIND_STATE;
		logic [POS_W-1:0] collected    = '0;
		logic [31:0]      window       = '0;
		logic [23:0]      recent       = '0;
		result_t          pending_frames[$];
		int               errors       = 0;

		function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [7:0] val);
			if (idx == REG_STATE_COUNT) begin
				state_limit = val;
			end else if (idx == REG_CONFIG_COUNT) begin
				config_limit = val;
			end
		endfunction

		function void note_byte(logic [7:0] b);
			logic [7:0]       want;
			logic [POS_W-1:0] pos;
			logic [POS_W-1:0] last;
			logic [7:0]       digit;
			logic [7:0]       lim;
			bit               done;
			bit               early;
			result_t          r;
			done  = 0;
			early = 0;
			// Header search: a mismatch drops the count and the byte is not retried.
			if (phase == PHASE_HUNT) begin
				if (matched == 0) begin
					matched = 3'd1;
					case (b)
						CHAR_S_LOWER: kind = KIND_STATE;
						CHAR_C_LOWER: kind = KIND_CONFIG;
						CHAR_D_LOWER: kind = KIND_DRIVE;
						default:      matched = 3'd0;
					endcase
				end else begin
					want = (matched == 1) ? CHAR_C : (matched == 2) ? CHAR_M : CHAR_D;
					if (b == want) begin
						matched = matched + 3'd1;
						if (matched >= 4) begin
							matched   = '0;
							phase     = PHASE_COLLECT;
							collected = '0;
							window    = '0;
						end
					end else begin
						matched = '0;
					end
				end
				return;
			end
			// Collection of payload and tail.
			pos  = collected;
			last = (kind == KIND_DRIVE) ? DRIVE_LAST_POS : DIGIT_LAST_POS;
			if (pos <= WINDOW_LAST_POS)
				window = {window[23:0], b};
			if (pos > WINDOW_LAST_POS && b == CHAR_CR && recent == {CHAR_E, CHAR_O, CHAR_L}) begin
				done  = 1;
				early = (pos < last);
			end
			if (pos >= last)
				done = 1;
			recent    = {recent[15:0], b};
			collected = pos + 1'b1;
			if (!done)
				return;
			// Build the result word of the closed frame.
			r.command_kind = kind;
			r.ended_early  = early;
			if (kind == KIND_DRIVE) begin
				r.value_first  = window[31:16];
				r.value_second = window[15:0];
				r.index_ok     = 1'b1;
			end else begin
				digit          = window[31:24];
				lim            = (kind == KIND_STATE) ? state_limit : config_limit;
				r.value_first  = {8'h00, digit} - {8'h00, ASCII_ZERO};
				r.value_second = '0;
				r.index_ok     = (digit >= ASCII_ZERO) && ((digit - ASCII_ZERO) < lim);
			end
			pending_frames.push_back(r);
			phase     = PHASE_HUNT;
			matched   = '0;
			collected = '0;
		endfunction

		function void check_frame(logic [39:0] tdata, logic [1:0] tuser);
			result_t want;
			if (pending_frames.size() == 0) begin
				$error("unexpected result word: tdata %h tuser %0d", tdata, tuser);
				errors++;
				return;
			end
			want = pending_frames.pop_front();
			if (tuser !== want.command_kind) begin
				$error("command_kind: expected %0d, actual %0d", want.command_kind, tuser);
				errors++;
			end
			if (tdata[15:0] !== want.value_first) begin
				$error("value_first: expected %0d, actual %0d",
					$signed(want.value_first), $signed(tdata[15:0]));
				errors++;
			end
			if (tdata[31:16] !== want.value_second) begin
				$error("value_second: expected %0d, actual %0d",
					$signed(want.value_second), $signed(tdata[31:16]));
				errors++;
			end
			if (tdata[32] !== want.index_ok) begin
				$error("index_ok: expected %0d, actual %0d", want.index_ok, tdata[32]);
				errors++;
			end
			if (tdata[33] !== want.ended_early) begin
				$error("ended_early: expected %0d, actual %0d", want.ended_early, tdata[33]);
				errors++;
			end
		endfunction
	endclass

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [7:0]             s_tdata   = '0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [39:0]            m_tdata;
	logic [1:0]             m_tuser;
	logic                   cfg_we    = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [7:0]             cfg_wdata = '0;

	frame_tracker tracker = new();
	bit           quiet       = 0;
	int           bytes_sent  = 0;
	int           idle_cycles = 0;

	command_frame_deframer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Clock.
	initial begin
		forever #1 clk = ~clk;
	end

	// Result side: check every accepted word against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_frame(m_tdata, m_tuser);
	end

	// Watchdog on cycles in which neither side moves a word.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// Receiver back-pressure in random bursts, none once the run goes quiet.
	initial begin
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Send one byte, with an optional idle burst before it, and note it once taken.
	task automatic push_byte(input logic [7:0] b);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		tracker.note_byte(b);
		bytes_sent++;
	endtask

	// Half of the time a frame character, else any byte.
	function automatic logic [7:0] pick_byte();
		logic [7:0] chars[11];
		chars = '{CHAR_S_LOWER, CHAR_C_LOWER, CHAR_D_LOWER, CHAR_C, CHAR_M, CHAR_D,
			CHAR_E, CHAR_O, CHAR_L, CHAR_CR, ASCII_ZERO};
		if ($urandom_range(0, 1) == 0)
			return chars[$urandom_range(0, 10)];
		return 8'($urandom_range(0, 255));
	endfunction

	// One frame with random content, sometimes broken, with noise in front.
	task automatic send_random_frame();
		logic [7:0] seq[$];
		logic [7:0] start;
		logic [7:0] extremes[4];
		int         n;
		int         kind_pick;
		extremes  = '{8'h00, 8'h7F, 8'h80, 8'hFF};
		seq       = {};
		kind_pick = $urandom_range(0, 2);
		start     = (kind_pick == 0) ? CHAR_S_LOWER :
			(kind_pick == 1) ? CHAR_C_LOWER : CHAR_D_LOWER;
		repeat ($urandom_range(0, 2)) seq.push_back(pick_byte());
		// Header, now and then doubled at its start or with one byte spoiled.
		if ($urandom_range(0, 19) == 0)
			seq.push_back(start);
		seq.push_back(start);
		seq.push_back(CHAR_C);
		seq.push_back(CHAR_M);
		seq.push_back(CHAR_D);
		if ($urandom_range(0, 9) == 0)
			seq[seq.size() - 1 - $urandom_range(0, 3)] = pick_byte();
		// Payload.
		if (kind_pick != 2) begin
			if ($urandom_range(0, 9) < 7)
				seq.push_back(ASCII_ZERO + 8'($urandom_range(0, 9)));
			else
				seq.push_back(8'($urandom_range(0, 255)));
		end else begin
			n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3) : DRIVE_PAYLOAD_BYTES;
			repeat (n) begin
				if ($urandom_range(0, 9) == 0)
					seq.push_back(extremes[$urandom_range(0, 3)]);
				else
					seq.push_back(8'($urandom_range(0, 255)));
			end
		end
		// Tail, mostly well formed.
		if ($urandom_range(0, 19) < 17) begin
			seq.push_back(CHAR_E);
			seq.push_back(CHAR_O);
			seq.push_back(CHAR_L);
			seq.push_back(CHAR_CR);
		end else begin
			repeat (TAIL_BYTES) seq.push_back(pick_byte());
		end
		foreach (seq[i]) push_byte(seq[i]);
	endtask

	// Finish any open frame, then hold the sender until every result is in.
	task automatic drain();
		while (tracker.phase == PHASE_COLLECT) push_byte(8'h00);
		s_tvalid <= 1'b0;
		while (tracker.pending_frames.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write both counts and the two spare indexes; the block is idle here.
	task automatic program_counts(input logic [7:0] state_v, input logic [7:0] config_v);
		logic [CFG_INDEX_W-1:0] idx[4];
		logic [7:0]             val[4];
		idx = '{REG_STATE_COUNT, REG_CONFIG_COUNT, REG_SPARE_LO, REG_SPARE_HI};
		val = '{state_v, config_v, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
		foreach (idx[i]) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_wdata <= val[i];
			@(posedge clk);
			tracker.set_reg(idx[i], val[i]);
		end
		cfg_we <= 1'b0;
	endtask

	// Main sequence: reset, directed frames, then random phases over several count settings.
	initial begin
		logic [7:0] directed[$];
		logic [7:0] state_vals[PHASE_COUNT];
		logic [7:0] config_vals[PHASE_COUNT];
		int         phase_start;
		directed = '{
			CHAR_S_LOWER, CHAR_S_LOWER, CHAR_C, CHAR_M, CHAR_D,
			CHAR_S_LOWER, CHAR_C, CHAR_M, CHAR_D, ASCII_ZERO, CHAR_E, CHAR_O, CHAR_L, CHAR_CR,
			CHAR_D_LOWER, CHAR_C, CHAR_M, CHAR_D, 8'h80, 8'h00, 8'h7F, 8'hFF,
			CHAR_E, CHAR_O, CHAR_L, CHAR_CR};
		state_vals  = '{8'd0, 8'd1, 8'd255, 8'($urandom_range(1, 254)), 8'd8};
		config_vals = '{8'd255, 8'd1, 8'd0, 8'($urandom_range(1, 254)), 8'd8};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) push_byte(directed[i]);
		drain();

		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			program_counts(state_vals[ph], config_vals[ph]);
			if (ph == PHASE_COUNT - 1)
				quiet = 1;
			phase_start = bytes_sent;
			while (bytes_sent - phase_start < PHASE_BYTES) send_random_frame();
			drain();
		end

		repeat (10) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending_frames.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ----- command_frame_deframer.f -----
+incdir+rtl/core
rtl/core/cfd_pkg.sv
rtl/core/cfd_framer.sv
rtl/core/cfd_out_reg.sv
rtl/core/command_frame_deframer.sv
sim/tb_command_frame_deframer.sv
